// ----- rtl/mfac_compact_form_controller_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the compact-form model-free adaptive controller.
// They expand to concurrent assertions in simulation and to nothing in
// synthesis. The clock is aclk and the checks are off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef MFAC_COMPACT_FORM_CONTROLLER_MACROS_SVH
`define MFAC_COMPACT_FORM_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MFAC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MFAC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFAC_ASSERT_IMP(label, ante, cons, msg)
`define MFAC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/mfac_pkg.sv -----
// ---------------------------------------------------------------------------
// mfac_pkg
// Shared widths, register indexes, status types and saturation helper of
// the compact-form model-free adaptive controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfac_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int GAIN_W        = 18;
    localparam int PEN_W         = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SAT_IN_W      = PROD_W;
    // Numerator of a gain term: 18-bit gain times a 32-bit signed value.
    localparam int NUM_W         = GAIN_W + DATA_W;
    localparam int MAG_W         = NUM_W - 1;
    // Quotient bits developed by the divider; larger quotients saturate.
    localparam int QUOT_BITS     = DATA_W + 1;
    localparam int HI_W          = MAG_W - QUOT_BITS;
    localparam int CNT_W         = $clog2(QUOT_BITS);
    localparam int CFG_IDX_W     = 8;

    localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(32768);
    localparam logic [PEN_W-1:0]  PEN_RST  = PEN_W'(65536);

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHI_STEP_GAIN        = 8'd0,
        CFG_PHI_WEIGHT_PENALTY   = 8'd1,
        CFG_DRIVE_STEP_GAIN      = 8'd2,
        CFG_DRIVE_CHANGE_PENALTY = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-DATA_W:0] top;
        logic signed [DATA_W-1:0] r;
        top = v[SAT_IN_W-1:DATA_W-1];
        if (!v[SAT_IN_W-1] && (|top)) begin
            r = DATA_MAX;
        end else if (v[SAT_IN_W-1] && !(&top)) begin
            r = DATA_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mfac_mul.sv -----
// ---------------------------------------------------------------------------
// mfac_mul
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfac_mul
    import mfac_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     issue,
    input  wire logic signed [DATA_W-1:0] op_a,
    input  wire logic signed [DATA_W-1:0] op_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // The product holds until the next issue.
    always_ff @(posedge aclk) begin
        if (issue) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/mfac_div.sv -----
// ---------------------------------------------------------------------------
// mfac_div
// Restoring divider, one quotient bit a cycle, signed numerator over a
// positive denominator, quotient truncated toward zero and saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfac_div
    import mfac_pkg::*;
#(
    parameter int DEN_W = 2 * DATA_W - 1 - FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]         den,
    output div_stat_t                     stat,
    output logic signed [DATA_W-1:0]      quot
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [DEN_W-1:0]       rem_reg, rem_next;
    logic [QUOT_BITS-1:0]   qsh_reg, qsh_next;

    logic [MAG_W-1:0]       mag;
    logic [DEN_W:0]         trial;
    logic                   big_pos, big_neg;
    logic [DATA_W-1:0]      q_lo;

    assign mag   = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    assign trial = {rem_reg, qsh_reg[QUOT_BITS-1]} - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        qsh_next  = qsh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[NUM_W-1];
            // Quotient needs more than the developed bits: saturate.
            ovf_next  = DEN_W'(mag[MAG_W-1:QUOT_BITS]) >= den;
            den_next  = den;
            rem_next  = DEN_W'(mag[MAG_W-1:QUOT_BITS]);
            qsh_next  = mag[QUOT_BITS-1:0];
        end else if (busy_reg) begin
            if (!trial[DEN_W]) begin
                rem_next = trial[DEN_W-1:0];
            end else begin
                rem_next = {rem_reg[DEN_W-2:0], qsh_reg[QUOT_BITS-1]};
            end
            qsh_next = {qsh_reg[QUOT_BITS-2:0], !trial[DEN_W]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUOT_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        qsh_reg <= qsh_next;
    end

    assign q_lo    = qsh_reg[DATA_W-1:0];
    assign big_pos = ovf_reg || qsh_reg[QUOT_BITS-1] || qsh_reg[DATA_W-1];
    assign big_neg = ovf_reg || qsh_reg[QUOT_BITS-1]
                     || (qsh_reg[DATA_W-1] && (|qsh_reg[DATA_W-2:0]));

    always_comb begin
        if (!neg_reg && big_pos) begin
            quot = DATA_MAX;
        end else if (neg_reg && big_neg) begin
            quot = DATA_MIN;
        end else if (neg_reg) begin
            quot = -$signed(q_lo);
        end else begin
            quot = $signed(q_lo);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/mfac_compact_form_controller.sv -----
// ---------------------------------------------------------------------------
// mfac_compact_form_controller
// Compact-form model-free adaptive controller: phi estimate update and
// drive update in signed fixed point, built round a shared multiplier and
// a shared bit-serial divider.
// ---------------------------------------------------------------------------
// Usage. Each input beat on the s_ channel carries the measured plant
// output and the target for the next step. The block first refines its
// pseudo-partial-derivative estimate phi, then forms the new drive, and
// returns one beat on the m_ channel with the drive and the updated phi.
// Configuration beats on the cfg_ channel set eta, mu, rho and lambda by
// index; cfg_ready is always high and writes are meant for idle periods.
// Writes to unknown indexes are dropped.
// Sequencing. From acceptance to its result being valid, an item makes
// seven passes through the shared multiplier and two runs of the shared
// divider, under a one-hot sequencer. s_ready is high only while the
// sequencer is idle, so the next item may be taken as soon as the result
// is loaded, even while that result still waits; no new item is taken
// while the current one is still in work.
// Reset clears the sequencer and output valid, sets phi to one and the
// drive, drive change and last measurement to zero, and loads the
// register reset values. If the receiver stalls, the sequencer holds in
// its final step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "mfac_compact_form_controller_macros.svh"

module mfac_compact_form_controller
    import mfac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [PEN_W-1:0]         cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [DATA_W-1:0] s_y_measured,
    input  wire logic signed [DATA_W-1:0] s_y_target,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_drive,
    output logic signed [DATA_W-1:0]      m_phi_out
);

    // Denominator width: penalty plus the scaled square of a 32-bit value.
    localparam int DEN_W = 2 * DATA_W - 1 - FRAC_BITS;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SQ1   = 14'b00000000000010,
        ST_PHD   = 14'b00000000000100,
        ST_NUM1  = 14'b00000000001000,
        ST_DIV1  = 14'b00000000010000,
        ST_WAIT1 = 14'b00000000100000,
        ST_CORR  = 14'b00000001000000,
        ST_PHI   = 14'b00000010000000,
        ST_SQ2   = 14'b00000100000000,
        ST_NUM2  = 14'b00001000000000,
        ST_DIV2  = 14'b00010000000000,
        ST_WAIT2 = 14'b00100000000000,
        ST_STEP  = 14'b01000000000000,
        ST_DRV   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [GAIN_W-1:0] eta_reg, eta_next;
    logic [PEN_W-1:0]  mu_reg, mu_next;
    logic [GAIN_W-1:0] rho_reg, rho_next;
    logic [PEN_W-1:0]  lam_reg, lam_next;

    // Loop state carried from item to item.
    logic signed [DATA_W-1:0] phi_reg, phi_next;
    logic signed [DATA_W-1:0] drive_reg, drive_next;
    logic signed [DATA_W-1:0] dstep_reg, dstep_next;
    logic signed [DATA_W-1:0] meas_reg, meas_next;

    // Working registers of the current item.
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic signed [DATA_W-1:0] dy_reg, dy_next;
    logic signed [DATA_W-1:0] e_reg, e_next;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic signed [DATA_W-1:0] gain_reg, gain_next;
    logic [DEN_W-1:0]         den_reg, den_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_drive_reg, out_drive_next;
    logic signed [DATA_W-1:0] out_phi_reg, out_phi_next;

    // Shared units.
    logic                     mul_issue;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_fx;
    logic                     div_start;
    div_stat_t                div_stat;
    logic signed [DATA_W-1:0] div_quot;
    logic [PEN_W-1:0]         mu_eff, lam_eff;
    logic [DEN_W-1:0]         sq_fx;
    logic signed [DATA_W-1:0] u_new;

    mfac_mul u_mul (
        .aclk  (aclk),
        .issue (mul_issue),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod)
    );

    mfac_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ($signed(prod[NUM_W-1:0])),
        .den     (den_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // Product scaled back to fixed point, rounding toward minus infinity.
    assign prod_fx = prod >>> FRAC_BITS;
    // Scaled square; a square is never negative, so the top bit is clear.
    assign sq_fx   = prod[PROD_W-2:FRAC_BITS];
    // A zero penalty acts as one LSB so that no denominator is zero.
    assign mu_eff  = (mu_reg == '0) ? PEN_W'(1) : mu_reg;
    assign lam_eff = (lam_reg == '0) ? PEN_W'(1) : lam_reg;
    assign u_new   = sat32(SAT_IN_W'(drive_reg) + SAT_IN_W'(sat32(prod_fx)));

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_issue = 1'b1;
        mul_a     = dstep_reg;
        mul_b     = dstep_reg;
        unique case (state_reg)
            ST_SQ1: begin
                mul_a = dstep_reg;
                mul_b = dstep_reg;
            end
            ST_PHD: begin
                mul_a = phi_reg;
                mul_b = dstep_reg;
            end
            ST_NUM1: begin
                mul_a = $signed(DATA_W'(eta_reg));
                mul_b = dstep_reg;
            end
            ST_CORR: begin
                mul_a = gain_reg;
                mul_b = err_reg;
            end
            ST_SQ2: begin
                mul_a = phi_reg;
                mul_b = phi_reg;
            end
            ST_NUM2: begin
                mul_a = $signed(DATA_W'(rho_reg));
                mul_b = phi_reg;
            end
            ST_STEP: begin
                mul_a = gain_reg;
                mul_b = e_reg;
            end
            default: begin
                mul_issue = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);

    // Sequencer and datapath registers.
    always_comb begin
        state_next     = state_reg;
        eta_next       = eta_reg;
        mu_next        = mu_reg;
        rho_next       = rho_reg;
        lam_next       = lam_reg;
        phi_next       = phi_reg;
        drive_next     = drive_reg;
        dstep_next     = dstep_reg;
        meas_next      = meas_reg;
        y_next         = y_reg;
        dy_next        = dy_reg;
        e_next         = e_reg;
        err_next       = err_reg;
        gain_next      = gain_reg;
        den_next       = den_reg;
        out_valid_next = out_valid_reg;
        out_drive_next = out_drive_reg;
        out_phi_next   = out_phi_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PHI_STEP_GAIN:        eta_next = cfg_data[GAIN_W-1:0];
                CFG_PHI_WEIGHT_PENALTY:   mu_next  = cfg_data;
                CFG_DRIVE_STEP_GAIN:      rho_next = cfg_data[GAIN_W-1:0];
                CFG_DRIVE_CHANGE_PENALTY: lam_next = cfg_data;
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    y_next     = s_y_measured;
                    dy_next    = sat32(SAT_IN_W'(s_y_measured) - SAT_IN_W'(meas_reg));
                    e_next     = sat32(SAT_IN_W'(s_y_target) - SAT_IN_W'(s_y_measured));
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1: begin
                state_next = ST_PHD;
            end
            ST_PHD: begin
                den_next   = DEN_W'(mu_eff) + sq_fx;
                state_next = ST_NUM1;
            end
            ST_NUM1: begin
                // Prediction error against the current estimate.
                err_next   = sat32(SAT_IN_W'(dy_reg) - prod_fx);
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                state_next = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (div_stat.done) begin
                    gain_next  = div_quot;
                    state_next = ST_CORR;
                end
            end
            ST_CORR: begin
                state_next = ST_PHI;
            end
            ST_PHI: begin
                phi_next   = sat32(SAT_IN_W'(phi_reg) + SAT_IN_W'(sat32(prod_fx)));
                state_next = ST_SQ2;
            end
            ST_SQ2: begin
                state_next = ST_NUM2;
            end
            ST_NUM2: begin
                den_next   = DEN_W'(lam_eff) + sq_fx;
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                state_next = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (div_stat.done) begin
                    gain_next  = div_quot;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = ST_DRV;
            end
            ST_DRV: begin
                // Wait here while the previous result is still held.
                if (!out_valid_reg || m_ready) begin
                    dstep_next     = sat32(SAT_IN_W'(u_new) - SAT_IN_W'(drive_reg));
                    drive_next     = u_new;
                    meas_next      = y_reg;
                    out_valid_next = 1'b1;
                    out_drive_next = u_new;
                    out_phi_next   = phi_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            eta_reg       <= GAIN_RST;
            mu_reg        <= PEN_RST;
            rho_reg       <= GAIN_RST;
            lam_reg       <= PEN_RST;
            phi_reg       <= DATA_W'(1) <<< FRAC_BITS;
            drive_reg     <= '0;
            dstep_reg     <= '0;
            meas_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            eta_reg       <= eta_next;
            mu_reg        <= mu_next;
            rho_reg       <= rho_next;
            lam_reg       <= lam_next;
            phi_reg       <= phi_next;
            drive_reg     <= drive_next;
            dstep_reg     <= dstep_next;
            meas_reg      <= meas_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        y_reg         <= y_next;
        dy_reg        <= dy_next;
        e_reg         <= e_next;
        err_reg       <= err_next;
        gain_reg      <= gain_next;
        den_reg       <= den_next;
        out_drive_reg <= out_drive_next;
        out_phi_reg   <= out_phi_next;
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_drive   = out_drive_reg;
    assign m_phi_out = out_phi_reg;

    // An accepted beat always starts the sequence at the first multiply.
    `MFAC_ASSERT_NXT(a_accept_starts, s_valid && s_ready, state_reg == ST_SQ1, "accept did not start the sequence")
    // The divider is never restarted while it is still working.
    `MFAC_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider started while busy")
    // A quotient only ever arrives while the sequencer waits for it.
    `MFAC_ASSERT_IMP(a_div_done_wait, div_stat.done, (state_reg == ST_WAIT1) || (state_reg == ST_WAIT2), "quotient arrived outside a wait step")
    // A new result only appears after the final step.
    `MFAC_ASSERT_IMP(a_out_from_drv, $rose(m_valid), $past(state_reg == ST_DRV), "result appeared outside the final step")

endmodule

`default_nettype wire

// ----- sim/mfac_compact_form_controller_tb.sv -----
// ---------------------------------------------------------------------------
// mfac_compact_form_controller_tb
// Self-checking bench for the compact-form model-free adaptive controller.
// A short table of directed samples comes first. Random samples follow, most
// of them from a closed loop round a crude first-order plant so that the
// phi estimate actually adapts. The bench runs through several register
// settings and several idling patterns on both channels. Every result beat
// is compared, field by field, with the bench's own fixed-point control law.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfac_compact_form_controller_tb;
    import mfac_pkg::*;

    localparam int     FRAC        = FRAC_BITS_DEF;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam int     STALL_LIMIT = 2000;
    localparam int     TAIL_CYCLES = 100;
    localparam int     PHASES      = 8;
    localparam int     PHASE_ITEMS = 185;
    localparam int     PROBE_COUNT = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] phi;
    } ctrl_result_t;

    // One directed sample; the result is typed in only where it is obvious.
    typedef struct packed {
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] t;
        logic                     typed;
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] phi;
    } probe_row_t;

    // The first three rows follow from the reset state: phi stays at one
    // while the drive change is tiny, and the drive gain is then a quarter.
    localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
        '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd65536},
        '{32'sd0, 32'sd4, 1'b1, 32'sd1, 32'sd65536},
        '{DATA_MIN, DATA_MAX, 1'b1, 32'sd536870912, 32'sd65536},
        '{DATA_MAX, DATA_MIN, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MIN, DATA_MAX, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MIN, DATA_MAX, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MIN, DATA_MAX, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MIN, DATA_MAX, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MAX, DATA_MIN, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MAX, DATA_MIN, 1'b0, 32'sd0, 32'sd0},
        '{DATA_MAX, DATA_MIN, 1'b0, 32'sd0, 32'sd0},
        '{-32'sd1, 32'sd1, 1'b0, 32'sd0, 32'sd0},
        '{32'sd1, -32'sd1, 1'b0, 32'sd0, 32'sd0},
        '{32'sh55555555, 32'shAAAAAAAA, 1'b0, 32'sd0, 32'sd0},
        '{32'shAAAAAAAA, 32'sh55555555, 1'b0, 32'sd0, 32'sd0},
        '{32'sh00010000, 32'sh00018000, 1'b0, 32'sd0, 32'sd0},
        '{32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
        '{32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0}
    };

    logic                     aclk;
    logic                     aresetn      = 1'b0;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index    = '0;
    logic [PEN_W-1:0]         cfg_data     = '0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_y_measured = '0;
    logic signed [DATA_W-1:0] s_y_target   = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic signed [DATA_W-1:0] m_drive;
    logic signed [DATA_W-1:0] m_phi_out;

    mfac_compact_form_controller dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_y_measured (s_y_measured),
        .s_y_target   (s_y_target),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive),
        .m_phi_out    (m_phi_out)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Controller state and registers as the bench sees them.
    longint phi_est;
    longint drive_q;
    longint drive_delta;
    longint meas_q;
    longint cfg_eta;
    longint cfg_mu;
    longint cfg_rho;
    longint cfg_lambda;

    ctrl_result_t pending_results [$];
    int           fault_count        = 0;
    int           stall_cycles       = 0;
    int           sender_idle_pct    = 0;
    int           receiver_stall_pct = 0;

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            return Q_MIN;
        end
        return v;
    endfunction

    // Floor of a product scaled back to fixed point.
    function automatic longint floor_frac(longint v);
        return v >>> FRAC;
    endfunction

    // gain * x / (penalty + x^2), quotient truncated towards zero.
    function automatic longint gain_term(longint gain, longint pen, longint x);
        longint den;
        longint num;
        den = ((pen == 0) ? 64'sd1 : pen) + floor_frac(x * x);
        num = gain * x;
        return clamp_q(num / den);
    endfunction

    // One control step: phi update, then the drive update. Advances the state.
    function automatic ctrl_result_t control_step(logic signed [DATA_W-1:0] y_in,
                                                  logic signed [DATA_W-1:0] t_in);
        longint       y;
        longint       t;
        longint       phi;
        longint       dy;
        longint       g;
        longint       err;
        longint       h;
        longint       e;
        longint       u;
        ctrl_result_t r;
        y   = y_in;
        t   = t_in;
        phi = phi_est;
        dy  = clamp_q(y - meas_q);
        g   = gain_term(cfg_eta, cfg_mu, drive_delta);
        err = clamp_q(dy - floor_frac(phi * drive_delta));
        phi = clamp_q(phi + clamp_q(floor_frac(g * err)));
        h   = gain_term(cfg_rho, cfg_lambda, phi);
        e   = clamp_q(t - y);
        u   = clamp_q(drive_q + clamp_q(floor_frac(h * e)));
        // The stored change is the one actually applied after saturation.
        drive_delta = clamp_q(u - drive_q);
        drive_q     = u;
        meas_q      = y;
        phi_est     = phi;
        r.drive     = u[DATA_W-1:0];
        r.phi       = phi[DATA_W-1:0];
        return r;
    endfunction

    // Random word whose magnitude spans every bit length.
    function automatic logic [DATA_W-1:0] scaled_word();
        logic [DATA_W-1:0] w;
        w = $urandom;
        return w >> $urandom_range(0, DATA_W - 1);
    endfunction

    function automatic logic signed [DATA_W-1:0] scaled_sample();
        logic signed [DATA_W-1:0] s;
        s = scaled_word();
        return $urandom_range(0, 1) ? -s : s;
    endfunction

    task automatic note_fault(string what, longint want, longint got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PEN_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PHI_STEP_GAIN:        cfg_eta    = data[GAIN_W-1:0];
            CFG_PHI_WEIGHT_PENALTY:   cfg_mu     = data;
            CFG_DRIVE_STEP_GAIN:      cfg_rho    = data[GAIN_W-1:0];
            CFG_DRIVE_CHANGE_PENALTY: cfg_lambda = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Present one sample beat, idling first as the current pattern asks.
    task automatic send_sample(input logic signed [DATA_W-1:0] y,
                               input logic signed [DATA_W-1:0] t,
                               input ctrl_result_t            want);
        @(negedge aclk);
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_y_measured <= y;
        s_y_target   <= t;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(want);
    endtask

    // Lower valid on the next falling edge and wait for every result.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= (receiver_stall_pct == 0) || ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Result checking and the no-progress watchdog.
    always @(posedge aclk) begin
        ctrl_result_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_fault("result beat with nothing pending, drive", 0, m_drive);
                end else begin
                    want = pending_results.pop_front();
                    if (m_drive !== want.drive) begin
                        note_fault("drive", want.drive, m_drive);
                    end
                    if (m_phi_out !== want.phi) begin
                        note_fault("phi_out", want.phi, m_phi_out);
                    end
                end
            end
        end
    end

    initial begin
        int                       p;
        int                       i;
        int                       kind;
        longint                   plant_y;
        logic signed [DATA_W-1:0] plant_target;
        logic signed [DATA_W-1:0] y_s;
        logic signed [DATA_W-1:0] t_s;
        ctrl_result_t             want;

        phi_est      = 64'sd1 << FRAC;
        drive_q      = 0;
        drive_delta  = 0;
        meas_q       = 0;
        cfg_eta      = GAIN_RST;
        cfg_mu       = PEN_RST;
        cfg_rho      = GAIN_RST;
        cfg_lambda   = PEN_RST;
        plant_y      = 0;
        plant_target = 32'sh00040000;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed samples under the reset register values.
        for (i = 0; i < PROBE_COUNT; i++) begin
            want = control_step(PROBE_ROWS[i].y, PROBE_ROWS[i].t);
            if (PROBE_ROWS[i].typed) begin
                want.drive = PROBE_ROWS[i].drive;
                want.phi   = PROBE_ROWS[i].phi;
            end
            send_sample(PROBE_ROWS[i].y, PROBE_ROWS[i].t, want);
        end

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: ;
                1: begin
                    cfg_write(CFG_PHI_STEP_GAIN, 32'd131072);
                    cfg_write(CFG_PHI_WEIGHT_PENALTY, 32'd1);
                    cfg_write(CFG_DRIVE_STEP_GAIN, 32'd131072);
                    cfg_write(CFG_DRIVE_CHANGE_PENALTY, 32'd1);
                end
                2: begin
                    cfg_write(CFG_PHI_STEP_GAIN, 32'd0);
                    cfg_write(CFG_PHI_WEIGHT_PENALTY, 32'hFFFF_FFFF);
                    cfg_write(CFG_DRIVE_STEP_GAIN, 32'd0);
                    cfg_write(CFG_DRIVE_CHANGE_PENALTY, 32'hFFFF_FFFF);
                end
                3: begin
                    // Full-scale 18-bit gains and zero penalties.
                    cfg_write(CFG_PHI_STEP_GAIN, 32'h0003_FFFF);
                    cfg_write(CFG_PHI_WEIGHT_PENALTY, 32'd0);
                    cfg_write(CFG_DRIVE_STEP_GAIN, 32'h0003_FFFF);
                    cfg_write(CFG_DRIVE_CHANGE_PENALTY, 32'd0);
                end
                4: begin
                    // Full words; the gain registers keep their low bits only.
                    cfg_write(CFG_PHI_STEP_GAIN, $urandom);
                    cfg_write(CFG_PHI_WEIGHT_PENALTY, $urandom);
                    cfg_write(CFG_DRIVE_STEP_GAIN, $urandom);
                    cfg_write(CFG_DRIVE_CHANGE_PENALTY, $urandom);
                end
                default: begin
                    if (p == 5) begin
                        cfg_write(CFG_UNMAPPED, 32'hFFFF_FFFF);
                    end
                    cfg_write(CFG_PHI_STEP_GAIN, $urandom_range(0, 131072));
                    cfg_write(CFG_PHI_WEIGHT_PENALTY, scaled_word());
                    cfg_write(CFG_DRIVE_STEP_GAIN, $urandom_range(0, 131072));
                    cfg_write(CFG_DRIVE_CHANGE_PENALTY, scaled_word());
                end
            endcase

            case (p % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 59;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 59;
                end
                default: begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase

            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 60) begin
                    drain_results();
                end
                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    // Closed loop: the plant sees the drive the controller should give.
                    if ($urandom_range(0, 99) < 4) begin
                        plant_target = scaled_sample();
                    end
                    y_s  = plant_y[DATA_W-1:0];
                    t_s  = plant_target;
                    want = control_step(y_s, t_s);
                    plant_y = clamp_q(((plant_y * 3) >>> 2) + (longint'(want.drive) >>> 1)
                                      + longint'($urandom_range(0, 255)) - 128);
                end else begin
                    if (kind < 90) begin
                        y_s = scaled_sample();
                        t_s = scaled_sample();
                    end else begin
                        y_s = $urandom;
                        t_s = $urandom;
                    end
                    want = control_step(y_s, t_s);
                end
                send_sample(y_s, t_s, want);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mfac_pkg.sv
rtl/mfac_mul.sv
rtl/mfac_div.sv
rtl/mfac_compact_form_controller.sv
sim/mfac_compact_form_controller_tb.sv
